// ===== rtl/viterbi_type_sequence_fusion_assert.svh =====
// assertion macros shared by the checker of the sequence fusion block
// no dependencies; taken in by `include
`ifndef VITERBI_TYPE_SEQUENCE_FUSION_ASSERT_SVH
`define VITERBI_TYPE_SEQUENCE_FUSION_ASSERT_SVH

// next-cycle implication, masked during reset
`define VTSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vtsf: next-cycle check failed");

// plain invariant, masked during reset
`define VTSF_ASSERT_HOLD(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("vtsf: invariant check failed");

// state right after a reset cycle
`define VTSF_ASSERT_AFTER_RESET(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("vtsf: post-reset check failed");

`endif

// ===== rtl/vtsf_pkg.sv =====
// shared types, constants and helpers of the sequence fusion block
// no dependencies
`default_nettype none

package vtsf_pkg;

    localparam int LANES        = 4;
    localparam int NUM_TYPES_DEF = 4;
    localparam int BEST_W       = 2;
    localparam int OBS_W        = 16;
    localparam int SCORE_W      = 32;
    localparam int WEIGHT_W     = 16;
    localparam int FRAC_W       = 12;
    localparam int PROD_W       = OBS_W + WEIGHT_W + 1;
    localparam int W_W          = PROD_W - FRAC_W;
    localparam int ACC_W        = SCORE_W + 4;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int QDEPTH       = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 3'd4;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd4096;
    localparam logic [PROD_W-1:0]   ROUND_HALF   = PROD_W'(2048);

    typedef logic signed [OBS_W-1:0] t_q88;
    typedef logic signed [W_W-1:0]   t_wval;
    typedef logic signed [SCORE_W-1:0] t_score;
    typedef t_q88 [LANES-1:0]                t_trow;
    typedef t_wval [LANES-1:0][LANES-1:0]    t_wtab;
    typedef t_score [LANES-1:0]              t_scores;

    typedef struct packed {
        logic                     seq_start;
        logic signed [OBS_W-1:0]  obs_0;
        logic signed [OBS_W-1:0]  obs_1;
        logic signed [OBS_W-1:0]  obs_2;
        logic signed [OBS_W-1:0]  obs_3;
    } t_in_item;

    typedef struct packed {
        logic [BEST_W-1:0]          best_type;
        logic signed [SCORE_W-1:0]  score_0;
        logic signed [SCORE_W-1:0]  score_1;
        logic signed [SCORE_W-1:0]  score_2;
        logic signed [SCORE_W-1:0]  score_3;
    } t_out_item;

    function automatic logic signed [SCORE_W-1:0] sat_score(
        input logic signed [ACC_W-1:0] v
    );
        logic ovf;
        ovf = (v[ACC_W-1:SCORE_W-1] != {(ACC_W-SCORE_W+1){1'b0}}) &&
              (v[ACC_W-1:SCORE_W-1] != {(ACC_W-SCORE_W+1){1'b1}});
        if (!ovf) begin
            return v[SCORE_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(SCORE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SCORE_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/viterbi_type_sequence_fusion.sv =====
// top level of the sequence fusion block: config, front queue and back end
// depends on vtsf_pkg, vtsf_cfg, vtsf_front, vtsf_back
//
// channel   direction  handshake                 payload
// input     in         i_valid / o_stall         i_data (seq_start, obs_0..obs_3)
// output    out        o_valid / i_stall         o_data (best_type, score_0..score_3)
// config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// one frame per cycle sustained while the output is not stalled
// from input accept to output valid a frame passes the queue, the path score registers and the output register
// config writes land in the row and weight registers, which feed the registered transition table
// reset: rows zero, weight 1.0, path scores zero, queue and output empty
// a four-entry queue absorbs output stall; o_stall rises only when it is full
`default_nettype none

module viterbi_type_sequence_fusion #(
    parameter int NUM_TYPES = vtsf_pkg::NUM_TYPES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire vtsf_pkg::t_in_item             i_data,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output vtsf_pkg::t_out_item                 o_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [vtsf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [vtsf_pkg::CFG_W-1:0]     i_cfg_data
);

    vtsf_pkg::t_trow    w_row0;
    vtsf_pkg::t_wtab    w_wtab;
    vtsf_pkg::t_in_item w_q_item;
    logic               w_q_valid;
    logic               w_q_pop;

    vtsf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_row0     (w_row0),
        .o_wtab     (w_wtab)
    );

    vtsf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data),
        .o_q_item  (w_q_item),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop)
    );

    vtsf_back #(
        .NUM_TYPES (NUM_TYPES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_item  (w_q_item),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_row0    (w_row0),
        .i_wtab    (w_wtab),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

endmodule

`default_nettype wire

// ===== rtl/vtsf_cfg.sv =====
// configuration registers and the registered table of weighted transitions
// depends on vtsf_pkg
`default_nettype none

module vtsf_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [vtsf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [vtsf_pkg::CFG_W-1:0]     i_cfg_data,
    output vtsf_pkg::t_trow                     o_row0,
    output vtsf_pkg::t_wtab                     o_wtab
);

    logic [vtsf_pkg::CFG_W-1:0]    r_row [vtsf_pkg::LANES];
    logic [vtsf_pkg::WEIGHT_W-1:0] r_weight;
    vtsf_pkg::t_wtab               r_wtab;
    vtsf_pkg::t_wtab               n_wtab;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < vtsf_pkg::LANES; l++) begin
                r_row[l] <= '0;
            end
            r_weight <= vtsf_pkg::WEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vtsf_pkg::CFG_ROW0:   r_row[0] <= i_cfg_data;
                vtsf_pkg::CFG_ROW1:   r_row[1] <= i_cfg_data;
                vtsf_pkg::CFG_ROW2:   r_row[2] <= i_cfg_data;
                vtsf_pkg::CFG_ROW3:   r_row[3] <= i_cfg_data;
                vtsf_pkg::CFG_WEIGHT: r_weight <= i_cfg_data[vtsf_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // w = floor((t * alpha + 2048) / 4096)
    always_comb begin
        logic signed [vtsf_pkg::PROD_W-1:0] prod;
        logic signed [vtsf_pkg::OBS_W-1:0]  t;
        for (int l = 0; l < vtsf_pkg::LANES; l++) begin
            for (int r = 0; r < vtsf_pkg::LANES; r++) begin
                t    = r_row[l][r*vtsf_pkg::OBS_W +: vtsf_pkg::OBS_W];
                prod = t * $signed({1'b0, r_weight});
                prod = prod + $signed(vtsf_pkg::ROUND_HALF);
                n_wtab[l][r] = prod[vtsf_pkg::PROD_W-1:vtsf_pkg::FRAC_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wtab <= n_wtab;
    end

    always_comb begin
        for (int r = 0; r < vtsf_pkg::LANES; r++) begin
            o_row0[r] = r_row[0][r*vtsf_pkg::OBS_W +: vtsf_pkg::OBS_W];
        end
    end

    assign o_wtab = r_wtab;

endmodule

`default_nettype wire

// ===== rtl/vtsf_front.sv =====
// front end: takes frames in and holds them in a short queue for the back end
// depends on vtsf_pkg
`default_nettype none

module vtsf_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire vtsf_pkg::t_in_item i_data,
    output vtsf_pkg::t_in_item      o_q_item,
    output logic                    o_q_valid,
    input  wire logic               i_q_pop
);

    localparam int QA_W = $clog2(vtsf_pkg::QDEPTH);
    localparam int QC_W = $clog2(vtsf_pkg::QDEPTH + 1);

    vtsf_pkg::t_in_item r_mem [vtsf_pkg::QDEPTH];
    logic [QA_W-1:0]    r_wr;
    logic [QA_W-1:0]    r_rd;
    logic [QC_W-1:0]    r_cnt;
    logic               w_full;
    logic               w_push;
    logic               w_pop;

    assign w_full    = (r_cnt == QC_W'(vtsf_pkg::QDEPTH));
    assign w_push    = i_valid && !w_full;
    assign w_pop     = i_q_pop && (r_cnt != '0);
    assign o_stall   = w_full;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vtsf_back.sv =====
// back end: path score registers, best class pick and the output register
// depends on vtsf_pkg and vtsf_core
`default_nettype none

module vtsf_back #(
    parameter int NUM_TYPES = vtsf_pkg::NUM_TYPES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire vtsf_pkg::t_in_item  i_q_item,
    input  wire logic                i_q_valid,
    output logic                     o_q_pop,
    input  wire vtsf_pkg::t_trow     i_row0,
    input  wire vtsf_pkg::t_wtab     i_wtab,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output vtsf_pkg::t_out_item      o_data
);

    vtsf_pkg::t_scores           r_path;
    vtsf_pkg::t_scores           n_path;
    logic                        r_s1_valid;
    logic                        r_out_valid;
    vtsf_pkg::t_out_item         r_out;
    logic [vtsf_pkg::BEST_W-1:0] w_best;
    logic                        w_s2_adv;
    logic                        w_pop;

    vtsf_core #(
        .NUM_TYPES (NUM_TYPES)
    ) u_step (
        .i_path (r_path),
        .i_item (i_q_item),
        .i_row0 (i_row0),
        .i_wtab (i_wtab),
        .o_path (n_path)
    );

    assign w_s2_adv = !r_out_valid || !i_stall;
    assign w_pop    = i_q_valid && (!r_s1_valid || w_s2_adv);
    assign o_q_pop  = w_pop;

    always_comb begin
        w_best = '0;
        for (int r = 1; r < vtsf_pkg::LANES; r++) begin
            if (r < NUM_TYPES && r_path[r] > r_path[w_best]) begin
                w_best = vtsf_pkg::BEST_W'(r);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_path <= n_path;
            end
            if (w_pop) begin
                r_s1_valid <= 1'b1;
            end else if (w_s2_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s2_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_adv && r_s1_valid) begin
            r_out.best_type <= w_best;
            r_out.score_0   <= r_path[0];
            r_out.score_1   <= r_path[1];
            r_out.score_2   <= r_path[2];
            r_out.score_3   <= r_path[3];
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/vtsf_core.sv =====
// max-plus step: next path scores from the previous ones and one frame, or from row 0 and the frame at seq_start
// depends on vtsf_pkg
`default_nettype none

module vtsf_core #(
    parameter int NUM_TYPES = vtsf_pkg::NUM_TYPES_DEF
) (
    input  wire vtsf_pkg::t_scores  i_path,
    input  wire vtsf_pkg::t_in_item i_item,
    input  wire vtsf_pkg::t_trow    i_row0,
    input  wire vtsf_pkg::t_wtab    i_wtab,
    output vtsf_pkg::t_scores       o_path
);

    logic signed [vtsf_pkg::OBS_W-1:0] w_obs [vtsf_pkg::LANES];

    assign w_obs[0] = i_item.obs_0;
    assign w_obs[1] = i_item.obs_1;
    assign w_obs[2] = i_item.obs_2;
    assign w_obs[3] = i_item.obs_3;

    always_comb begin
        logic signed [vtsf_pkg::ACC_W-1:0] top;
        logic signed [vtsf_pkg::ACC_W-1:0] cand;
        logic signed [vtsf_pkg::ACC_W-1:0] sum;
        for (int r = 0; r < vtsf_pkg::LANES; r++) begin
            top = '0;
            for (int l = 0; l < vtsf_pkg::LANES; l++) begin
                cand = vtsf_pkg::ACC_W'(i_path[l]) +
                       vtsf_pkg::ACC_W'($signed(i_wtab[l][r]));
                if (l < NUM_TYPES && (l == 0 || cand > top)) begin
                    top = cand;
                end
            end
            if (i_item.seq_start) begin
                sum = vtsf_pkg::ACC_W'(w_obs[r]) + vtsf_pkg::ACC_W'($signed(i_row0[r]));
            end else begin
                sum = top + vtsf_pkg::ACC_W'(w_obs[r]);
            end
            o_path[r] = (r < NUM_TYPES) ? vtsf_pkg::sat_score(sum) : '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vtsf_chk.sv =====
// port-level checker of the sequence fusion block, bound to the top level
// depends on vtsf_pkg and viterbi_type_sequence_fusion_assert.svh
`default_nettype none
`include "viterbi_type_sequence_fusion_assert.svh"

module vtsf_chk #(
    parameter int NUM_TYPES = vtsf_pkg::NUM_TYPES_DEF
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_stall,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire vtsf_pkg::t_out_item o_data
);

    logic signed [vtsf_pkg::SCORE_W-1:0] w_sc [vtsf_pkg::LANES];
    logic signed [vtsf_pkg::SCORE_W-1:0] w_top;
    logic                                w_above;
    logic                                w_tie_low;
    logic                                w_idle_bad;

    assign w_sc[0] = o_data.score_0;
    assign w_sc[1] = o_data.score_1;
    assign w_sc[2] = o_data.score_2;
    assign w_sc[3] = o_data.score_3;
    assign w_top   = w_sc[o_data.best_type];

    always_comb begin
        w_above    = 1'b0;
        w_tie_low  = 1'b0;
        w_idle_bad = (int'(o_data.best_type) >= NUM_TYPES);
        for (int k = 0; k < vtsf_pkg::LANES; k++) begin
            if (k < NUM_TYPES && w_sc[k] > w_top) begin
                w_above = 1'b1;
            end
            if (k < int'(o_data.best_type) && w_sc[k] == w_top) begin
                w_tie_low = 1'b1;
            end
            if (k >= NUM_TYPES && w_sc[k] != '0) begin
                w_idle_bad = 1'b1;
            end
        end
    end

    // no item shown and nothing refused straight after reset
    `VTSF_ASSERT_AFTER_RESET(a_reset_empty, i_clk, i_rst_n, !o_valid && !o_stall)
    // a stalled result stays put
    `VTSF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    // best class carries the top score, lowest index on ties
    `VTSF_ASSERT_HOLD(a_best_top, i_clk, i_rst_n, !o_valid || (!w_above && !w_tie_low))
    // unused classes stay at zero and never win
    `VTSF_ASSERT_HOLD(a_idle_lanes, i_clk, i_rst_n, !o_valid || !w_idle_bad)

endmodule

bind viterbi_type_sequence_fusion vtsf_chk #(
    .NUM_TYPES (NUM_TYPES)
) u_vtsf_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire
